FILE: rtl/u2u_pkg.sv
// shared types and constants for the utf-8 to utf-16 decoder
package u2u_pkg;

	localparam int BYTE_W = 8;
	localparam int UNIT_W = 16;
	localparam int LEN_W  = 2;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [UNIT_W-1:0] unit_t;
	typedef logic [LEN_W-1:0]  len_t;

	// sequence lengths, also used as the pending-length code (none = idle)
	localparam len_t LEN_NONE  = 2'd0;
	localparam len_t LEN_ONE   = 2'd1;
	localparam len_t LEN_TWO   = 2'd2;
	localparam len_t LEN_THREE = 2'd3;

	// lead and continuation byte patterns
	localparam byte_t ASCII_MASK  = 8'h80;
	localparam byte_t CONT_MASK   = 8'hC0;
	localparam byte_t CONT_CODE   = 8'h80;
	localparam byte_t LEAD2_MASK  = 8'hE0;
	localparam byte_t LEAD2_CODE  = 8'hC0;
	localparam byte_t LEAD3_MASK  = 8'hF0;
	localparam byte_t LEAD3_CODE  = 8'hE0;
	localparam byte_t CONT_BITS   = 8'h3F;
	localparam byte_t LEAD2_BITS  = 8'h1F;
	localparam byte_t LEAD3_BITS  = 8'h0F;

	localparam int CONT_PAYLOAD_W = 6;

	typedef struct packed {
		unit_t code_unit;
		len_t  seq_length;
	} result_t;

endpackage

FILE: rtl/u2u_channels.sv
// valid/ready channel interfaces for the byte input and the code unit output
interface u2u_in_if;
	import u2u_pkg::*;

	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  is_last;

	modport source (output valid, output data_byte, output is_last, input ready);
	modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface u2u_out_if;
	import u2u_pkg::*;

	logic  valid;
	logic  ready;
	unit_t code_unit;
	len_t  seq_length;

	modport source (output valid, output code_unit, output seq_length, input ready);
	modport sink (input valid, input code_unit, input seq_length, output ready);
endinterface

FILE: rtl/u2u_decode.sv
// sequence tracking state and per-byte decode logic
module u2u_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  u2u_pkg::byte_t   data_byte,
	input  logic             is_last,
	output logic             emit,
	output u2u_pkg::result_t result
);
	import u2u_pkg::*;

	len_t  expected_q;
	len_t  seen_q;
	unit_t partial_q;

	len_t  expected_d;
	len_t  seen_d;
	unit_t partial_d;

	always_comb begin
		logic  taken;
		len_t  seen_inc;
		unit_t shifted;

		taken      = 1'b0;
		seen_inc   = seen_q + LEN_ONE;
		shifted    = {partial_q[UNIT_W-CONT_PAYLOAD_W-1:0],
			data_byte[CONT_PAYLOAD_W-1:0]};
		expected_d = expected_q;
		seen_d     = seen_q;
		partial_d  = partial_q;
		emit       = 1'b0;
		result     = '0;

		if (accept) begin
			if (expected_q != LEN_NONE) begin
				if ((data_byte & CONT_MASK) == CONT_CODE) begin
					taken = 1'b1;
					if (seen_inc >= expected_q) begin
						emit              = 1'b1;
						result.code_unit  = shifted;
						result.seq_length = expected_q;
						expected_d        = LEN_NONE;
						seen_d            = LEN_NONE;
						partial_d         = '0;
					end else begin
						seen_d    = seen_inc;
						partial_d = shifted;
					end
				end else begin
					// broken sequence: drop it and treat this byte as a lead
					expected_d = LEN_NONE;
					seen_d     = LEN_NONE;
					partial_d  = '0;
				end
			end

			if (!taken) begin
				priority if ((data_byte & ASCII_MASK) == '0) begin
					emit              = 1'b1;
					result.code_unit  = {{(UNIT_W-BYTE_W){1'b0}}, data_byte};
					result.seq_length = LEN_ONE;
				end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
					expected_d = LEN_TWO;
					seen_d     = LEN_ONE;
					partial_d  = {{(UNIT_W-BYTE_W){1'b0}}, data_byte & LEAD2_BITS};
				end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
					expected_d = LEN_THREE;
					seen_d     = LEN_ONE;
					partial_d  = {{(UNIT_W-BYTE_W){1'b0}}, data_byte & LEAD3_BITS};
				end else begin
					// stray continuation or four-byte lead is dropped
				end
			end

			if (is_last) begin
				expected_d = LEN_NONE;
				seen_d     = LEN_NONE;
				partial_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= LEN_NONE;
			seen_q     <= LEN_NONE;
			partial_q  <= '0;
		end else begin
			expected_q <= expected_d;
			seen_q     <= seen_d;
			partial_q  <= partial_d;
		end
	end

endmodule

FILE: rtl/u2u_out_buf.sv
// two-entry result register with skid slot in front of the output channel
module u2u_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  u2u_pkg::result_t push_data,
	output logic             can_take,
	u2u_out_if.source        out_ch
);
	import u2u_pkg::*;

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop      = main_valid_q & out_ch.ready;
	assign can_take = ~skid_valid_q;

	assign out_ch.valid      = main_valid_q;
	assign out_ch.code_unit  = main_q.code_unit;
	assign out_ch.seq_length = main_q.seq_length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!main_valid_q || pop) begin
				// skid slot drains first; no push arrives while it is full
				main_valid_q <= skid_valid_q | push;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

FILE: rtl/utf8_to_utf16_bmp_decoder_unit.sv
// Decodes a UTF-8 byte stream into 16-bit code units of the basic multilingual
// plane, one byte per transfer on in_ch and one code unit per transfer on
// out_ch together with the number of bytes (1 to 3) that formed it. Bytes are
// taken at one per clock cycle while the skid slot is empty; each byte is
// decoded in the cycle it is taken and its code unit is registered in the
// result register, or in the skid slot while out_ch holds a waiting result. A
// two-entry result register lets the block keep taking bytes for one more
// result while out_ch is stalled. Stray continuation bytes and four-byte leads
// produce nothing; a sequence broken by a non-continuation byte is dropped and
// that byte starts afresh; a partial sequence open after the byte flagged
// is_last is dropped. No overlong or surrogate check is made.
module utf8_to_utf16_bmp_decoder_unit (
	input  logic      clk,
	input  logic      arst_n,
	u2u_in_if.sink    in_ch,
	u2u_out_if.source out_ch
);
	import u2u_pkg::*;

	logic    accept;
	logic    emit;
	logic    can_take;
	result_t result;

	assign in_ch.ready = can_take;
	assign accept      = in_ch.valid & can_take;

	u2u_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (in_ch.data_byte),
		.is_last   (in_ch.is_last),
		.emit      (emit),
		.result    (result)
	);

	u2u_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (result),
		.can_take  (can_take),
		.out_ch    (out_ch)
	);

`ifndef SYNTHESIS
	// skid slot only fills behind a waiting result
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> out_ch.valid)
		else $error("input stalled with no result waiting");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.seq_length != LEN_NONE)
		else $error("result with zero sequence length");

	a_one_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.seq_length == LEN_ONE) |-> out_ch.code_unit[15:7] == '0)
		else $error("one-byte result above 0x7f");

	a_two_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.seq_length == LEN_TWO) |-> out_ch.code_unit[15:11] == '0)
		else $error("two-byte result above 0x7ff");
`endif

endmodule
